FILE: rtl/core/ptrk_pkg.sv
// ----------------------------------------------------------------------------
// ptrk_pkg
// Shared types and constants of the pre-trade risk and position keeper.
// ----------------------------------------------------------------------------
package ptrk_pkg;

  localparam int unsigned NumSymbols = 256;
  localparam int unsigned SymIdxW    = $clog2(NumSymbols);
  localparam int unsigned QDepth     = 2;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgIdxOwnId    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxStartBal = 1'b1;

  localparam logic SideBuy = 1'b0;

  localparam logic [31:0] Div5Mul   = 32'hCCCC_CCCD;
  localparam int unsigned Div5Shift = 34;

  typedef enum logic [1:0] {
    OP_CHECK = 2'd0,
    OP_TRADE = 2'd1,
    OP_RESET = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    OT_LIMIT       = 3'd0,
    OT_STOP_LIMIT  = 3'd1,
    OT_STOP_MARKET = 3'd2,
    OT_MARKET      = 3'd3
  } otype_e;

  typedef enum logic [2:0] {
    K_NOP        = 3'd0,
    K_CHECK_BUY  = 3'd1,
    K_CHECK_SELL = 3'd2,
    K_TRADE      = 3'd3,
    K_RESET      = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [SymIdxW-1:0] sym;
    logic               ok;
    logic               my_side;
    logic [31:0]        qty;
    logic [63:0]        product;
  } entry_t;

endpackage

FILE: rtl/core/ptrk_ram.sv
// ----------------------------------------------------------------------------
// ptrk_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptrk_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/ptrk_fifo.sv
// ----------------------------------------------------------------------------
// ptrk_fifo
// Short queue of classified transactions between the front and back parts.
// ----------------------------------------------------------------------------
module ptrk_fifo
  import ptrk_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t wdata_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output entry_t rdata_o
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  entry_t          mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/core/ptrk_front.sv
// ----------------------------------------------------------------------------
// ptrk_front
// Accepts transactions, prices orders, forms price times quantity and
// classifies each transaction for the back part.
// ----------------------------------------------------------------------------
module ptrk_front
  import ptrk_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  symbol_i,
  input  logic        side_i,
  input  logic [2:0]  order_type_i,
  input  logic [31:0] quantity_i,
  input  logic [31:0] price_i,
  input  logic [31:0] stop_price_i,
  input  logic        ask_valid_i,
  input  logic [30:0] best_ask_i,
  input  logic [31:0] aggressor_id_i,
  input  logic [31:0] resting_id_i,
  input  logic [31:0] own_id_i,
  input  logic        fifo_full_i,
  output logic        push_o,
  output entry_t      entry_o
);

  typedef struct packed {
    logic [1:0]         op;
    logic [SymIdxW-1:0] sym;
    logic               side;
    logic [2:0]         otype;
    logic [31:0]        qty;
    logic [31:0]        price;
    logic [31:0]        stop;
    logic               ask_valid;
    logic [30:0]        ask;
    logic [26:0]        ask_div20;
    logic               agg_hit;
    logic               rest_hit;
  } s1_t;

  s1_t                s1_q, s1_d;
  logic               s1_v_q, s1_v_d;
  logic               load;
  logic [60:0]        div_mul;
  logic signed [32:0] price33;
  logic signed [32:0] qty33;
  logic signed [65:0] prod;
  logic               type_ok;

  // The market price floor(ask * 1.05) equals ask + floor(floor(ask / 4) / 5).
  assign div_mul = 61'(best_ask_i[30:2]) * 61'(Div5Mul);

  assign in_stall_o = s1_v_q & fifo_full_i;
  assign load       = in_valid_i & ~in_stall_o;
  assign push_o     = s1_v_q & ~fifo_full_i;

  always_comb begin
    s1_d   = s1_q;
    s1_v_d = s1_v_q;
    if (push_o) begin
      s1_v_d = 1'b0;
    end
    if (load) begin
      s1_v_d          = 1'b1;
      s1_d.op         = operation_i;
      s1_d.sym        = symbol_i[SymIdxW-1:0];
      s1_d.side       = side_i;
      s1_d.otype      = order_type_i;
      s1_d.qty        = quantity_i;
      s1_d.price      = price_i;
      s1_d.stop       = stop_price_i;
      s1_d.ask_valid  = ask_valid_i;
      s1_d.ask        = best_ask_i;
      s1_d.ask_div20  = div_mul[60:Div5Shift];
      s1_d.agg_hit    = (aggressor_id_i == own_id_i);
      s1_d.rest_hit   = (resting_id_i == own_id_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  assign qty33 = {s1_q.qty[31], s1_q.qty};
  assign prod  = 66'(price33) * 66'(qty33);

  always_comb begin
    price33         = {s1_q.price[31], s1_q.price};
    type_ok         = 1'b0;
    entry_o.kind    = K_NOP;
    entry_o.sym     = s1_q.sym;
    entry_o.ok      = 1'b0;
    entry_o.my_side = s1_q.side;
    entry_o.qty     = s1_q.qty;
    case (s1_q.otype)
      OT_LIMIT, OT_STOP_LIMIT: begin
        type_ok = 1'b1;
      end
      OT_STOP_MARKET: begin
        price33 = {s1_q.stop[31], s1_q.stop};
        type_ok = 1'b1;
      end
      OT_MARKET: begin
        price33 = {1'b0, 32'(s1_q.ask) + 32'(s1_q.ask_div20)};
        type_ok = s1_q.ask_valid;
      end
      default: begin
        type_ok = 1'b0;
      end
    endcase
    case (s1_q.op)
      OP_CHECK: begin
        if (s1_q.side != SideBuy) begin
          entry_o.kind = K_CHECK_SELL;
          entry_o.ok   = ($signed(s1_q.qty) > 0);
        end else begin
          entry_o.kind = K_CHECK_BUY;
          entry_o.ok   = ($signed(s1_q.qty) > 0) && type_ok && (price33 > 0);
        end
      end
      OP_TRADE: begin
        price33         = {s1_q.price[31], s1_q.price};
        entry_o.kind    = K_TRADE;
        entry_o.ok      = s1_q.agg_hit | s1_q.rest_hit;
        entry_o.my_side = s1_q.agg_hit ? s1_q.side : ~s1_q.side;
      end
      OP_RESET: begin
        entry_o.kind = K_RESET;
      end
      default: begin
        entry_o.kind = K_NOP;
      end
    endcase
    entry_o.product = prod[63:0];
  end

endmodule

FILE: rtl/core/ptrk_back.sv
// ----------------------------------------------------------------------------
// ptrk_back
// Executes classified transactions: reads the position table, decides checks,
// applies trades and resets, and holds the result register.
// ----------------------------------------------------------------------------
module ptrk_back
  import ptrk_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fifo_empty_i,
  input  entry_t      fifo_data_i,
  output logic        fifo_pop_o,
  input  logic [63:0] start_bal_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic        accepted_o,
  output logic        applied_o,
  output logic [63:0] balance_now_o,
  output logic [63:0] position_now_o
);

  typedef enum logic {
    B_IDLE,
    B_EXEC
  } bstate_e;

  bstate_e                 state_q, state_d;
  entry_t                  cur_q, cur_d;
  logic [63:0]             bal_q, bal_d;
  logic [NumSymbols-1:0]   valid_q, valid_d;
  logic                    out_valid_q, out_valid_d;
  logic                    acc_q, acc_d;
  logic                    app_q, app_d;
  logic [63:0]             balo_q, balo_d;
  logic [63:0]             poso_q, poso_d;

  logic [63:0]             rdata;
  logic signed [63:0]      pos_cur;
  logic signed [63:0]      pos_new;
  logic signed [63:0]      qty64;
  logic                    fire;
  logic                    we;

  ptrk_ram #(
    .Width(64),
    .Depth(NumSymbols)
  ) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(cur_q.sym),
    .wdata_i(pos_new),
    .re_i   (fifo_pop_o),
    .raddr_i(fifo_data_i.sym),
    .rdata_o(rdata)
  );

  assign fifo_pop_o = (state_q == B_IDLE) && !fifo_empty_i;
  assign fire       = (state_q == B_EXEC) && (!out_valid_q || !out_stall_i);
  assign pos_cur    = valid_q[cur_q.sym] ? $signed(rdata) : 64'sd0;
  assign qty64      = {{32{cur_q.qty[31]}}, cur_q.qty};

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    bal_d       = bal_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q & out_stall_i;
    acc_d       = acc_q;
    app_d       = app_q;
    balo_d      = balo_q;
    poso_d      = poso_q;
    pos_new     = pos_cur;
    we          = 1'b0;

    if (fire) begin
      state_d     = B_IDLE;
      out_valid_d = 1'b1;
      acc_d       = 1'b0;
      app_d       = 1'b0;
      poso_d      = pos_cur;
      case (cur_q.kind)
        K_CHECK_BUY: begin
          acc_d = cur_q.ok && ($signed(cur_q.product) <= $signed(bal_q));
        end
        K_CHECK_SELL: begin
          acc_d = cur_q.ok && (pos_cur >= qty64);
        end
        K_TRADE: begin
          if (cur_q.ok) begin
            if (cur_q.my_side == SideBuy) begin
              bal_d   = bal_q - cur_q.product;
              pos_new = pos_cur + qty64;
            end else begin
              bal_d   = bal_q + cur_q.product;
              pos_new = pos_cur - qty64;
            end
            we                  = 1'b1;
            valid_d[cur_q.sym]  = 1'b1;
            app_d               = 1'b1;
            poso_d              = pos_new;
          end
        end
        K_RESET: begin
          bal_d   = start_bal_i;
          valid_d = '0;
          poso_d  = '0;
        end
        default: begin
        end
      endcase
      balo_d = bal_d;
    end

    if (fifo_pop_o) begin
      cur_d   = fifo_data_i;
      state_d = B_EXEC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      bal_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bal_q       <= bal_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    acc_q  <= acc_d;
    app_q  <= app_d;
    balo_q <= balo_d;
    poso_q <= poso_d;
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = acc_q;
  assign applied_o      = app_q;
  assign balance_now_o  = balo_q;
  assign position_now_o = poso_q;

endmodule

FILE: rtl/core/pre_trade_risk_and_position_keeper.sv
// ----------------------------------------------------------------------------
// pre_trade_risk_and_position_keeper
// Pre-trade risk check with cash balance and per-symbol position keeping.
// ----------------------------------------------------------------------------
// Each input transaction (check, trade, reset, none) yields exactly one result
// transaction carrying the accept flag, the applied flag, the balance and
// the position of the transaction's symbol after it has been carried out.
// Both channels use valid and stall; a transaction moves when valid is high
// and stall is low. The user writes configuration registers through the plain
// write port only while no transaction is in flight; this is not enforced.
// The front part registers a transaction, prices it and forms price times
// quantity; a two-entry queue separates it from the back part. The back part
// reads the position table and then executes and writes back, and it takes a
// new transaction from the queue only once the last one is finished. A result
// passes the front register, the queue, the back part's transaction register
// and the result register.
// When the receiver stalls, the result register holds, the back part waits,
// the queue fills and the input stall rises. Reset clears the balance, all
// positions and all control state; a reset transaction restores the balance
// to the starting balance and clears all positions.
// ----------------------------------------------------------------------------
module pre_trade_risk_and_position_keeper
  import ptrk_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic [7:0]         symbol_i,
  input  logic               side_i,
  input  logic [2:0]         order_type_i,
  input  logic [31:0]        quantity_i,
  input  logic [31:0]        price_i,
  input  logic [31:0]        stop_price_i,
  input  logic               ask_valid_i,
  input  logic [30:0]        best_ask_i,
  input  logic [31:0]        aggressor_id_i,
  input  logic [31:0]        resting_id_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               accepted_o,
  output logic               applied_o,
  output logic [63:0]        balance_now_o,
  output logic [63:0]        position_now_o
);

  logic [31:0] own_id_q, own_id_d;
  logic [63:0] start_bal_q, start_bal_d;
  logic        fifo_full;
  logic        fifo_empty;
  logic        push;
  logic        pop;
  entry_t      push_entry;
  entry_t      pop_entry;

  always_comb begin
    own_id_d    = own_id_q;
    start_bal_d = start_bal_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIdxOwnId: begin
          own_id_d = cfg_wdata_i[31:0];
        end
        CfgIdxStartBal: begin
          start_bal_d = cfg_wdata_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q    <= '0;
      start_bal_q <= '0;
    end else begin
      own_id_q    <= own_id_d;
      start_bal_q <= start_bal_d;
    end
  end

  ptrk_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .symbol_i      (symbol_i),
    .side_i        (side_i),
    .order_type_i  (order_type_i),
    .quantity_i    (quantity_i),
    .price_i       (price_i),
    .stop_price_i  (stop_price_i),
    .ask_valid_i   (ask_valid_i),
    .best_ask_i    (best_ask_i),
    .aggressor_id_i(aggressor_id_i),
    .resting_id_i  (resting_id_i),
    .own_id_i      (own_id_q),
    .fifo_full_i   (fifo_full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  ptrk_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(push_entry),
    .full_o (fifo_full),
    .pop_i  (pop),
    .empty_o(fifo_empty),
    .rdata_o(pop_entry)
  );

  ptrk_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_empty_i  (fifo_empty),
    .fifo_data_i   (pop_entry),
    .fifo_pop_o    (pop),
    .start_bal_i   (start_bal_q),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .accepted_o    (accepted_o),
    .applied_o     (applied_o),
    .balance_now_o (balance_now_o),
    .position_now_o(position_now_o)
  );

endmodule

FILE: tb/pre_trade_risk_and_position_keeper_tb.sv
// ----------------------------------------------------------------------------
// pre_trade_risk_and_position_keeper_tb
// Self-checking testbench for the pre-trade risk and position keeper. A
// behavioral model of the balance and the position table predicts every
// result transaction. Directed transactions cover order pricing, rejection
// rules, trade sides and register extremes. Randomized phases with changing
// registers and, in all but one phase, random idling on both channels follow.
// ----------------------------------------------------------------------------
module pre_trade_risk_and_position_keeper_tb;
  import ptrk_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned PhaseItems    = 260;

  typedef struct {
    op_e         op;
    logic [7:0]  sym;
    logic        side;
    logic [2:0]  otype;
    logic [31:0] qty;
    logic [31:0] price;
    logic [31:0] stop;
    logic        ask_ok;
    logic [30:0] ask;
    logic [31:0] aggr;
    logic [31:0] rest;
  } risk_item_t;

  typedef struct {
    logic        acc;
    logic        app;
    logic [63:0] bal;
    logic [63:0] pos;
  } risk_result_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i      = '0;
  logic [63:0]        cfg_wdata_i    = '0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [1:0]         operation_i    = '0;
  logic [7:0]         symbol_i       = '0;
  logic               side_i         = 1'b0;
  logic [2:0]         order_type_i   = '0;
  logic [31:0]        quantity_i     = '0;
  logic [31:0]        price_i        = '0;
  logic [31:0]        stop_price_i   = '0;
  logic               ask_valid_i    = 1'b0;
  logic [30:0]        best_ask_i     = '0;
  logic [31:0]        aggressor_id_i = '0;
  logic [31:0]        resting_id_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic               accepted_o;
  logic               applied_o;
  logic [63:0]        balance_now_o;
  logic [63:0]        position_now_o;

  pre_trade_risk_and_position_keeper u_top (.*);

  logic [31:0] own_id        = '0;
  logic [63:0] start_balance = '0;
  logic [63:0] cash_balance  = '0;
  logic [63:0] pos_table [NumSymbols];
  bit          pos_known [NumSymbols];

  risk_result_t expected_results [$];
  int          mismatch_count = 0;
  bit          no_idle        = 1'b0;
  int          rx_stall_left  = 0;
  int          quiet_cycles   = 0;

  always #6 clk_i = ~clk_i;

  function automatic logic [63:0] sext32(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] read_pos(logic [7:0] sym);
    return pos_known[sym] ? pos_table[sym] : 64'd0;
  endfunction

  function automatic logic order_passes(risk_item_t it);
    logic signed [63:0] q;
    logic signed [63:0] px;
    logic signed [63:0] cost;
    logic [63:0]        mkt;
    q = sext32(it.qty);
    if (q <= 0) return 1'b0;
    if (it.side != SideBuy) return $signed(read_pos(it.sym)) >= q;
    case (it.otype)
      OT_LIMIT, OT_STOP_LIMIT: px = sext32(it.price);
      OT_STOP_MARKET: px = sext32(it.stop);
      OT_MARKET: begin
        if (!it.ask_ok) return 1'b0;
        mkt = ({33'd0, it.ask} * 64'd105) / 64'd100;
        px = mkt;
      end
      default: return 1'b0;
    endcase
    if (px <= 0) return 1'b0;
    cost = px * q;
    return cost <= $signed(cash_balance);
  endfunction

  function automatic logic trade_applies(risk_item_t it);
    logic [63:0] change;
    logic [63:0] qty64;
    logic        my_side;
    qty64 = sext32(it.qty);
    change = sext32(it.price) * qty64;
    if (it.aggr == own_id) my_side = it.side;
    else if (it.rest == own_id) my_side = ~it.side;
    else return 1'b0;
    pos_table[it.sym] = read_pos(it.sym);
    pos_known[it.sym] = 1'b1;
    if (my_side == SideBuy) begin
      cash_balance = cash_balance - change;
      pos_table[it.sym] = pos_table[it.sym] + qty64;
    end else begin
      cash_balance = cash_balance + change;
      pos_table[it.sym] = pos_table[it.sym] - qty64;
    end
    return 1'b1;
  endfunction

  function automatic risk_result_t risk_keeper_step(risk_item_t it);
    risk_result_t r;
    r.acc = 1'b0;
    r.app = 1'b0;
    case (it.op)
      OP_CHECK: r.acc = order_passes(it);
      OP_TRADE: r.app = trade_applies(it);
      OP_RESET: begin
        cash_balance = start_balance;
        for (int i = 0; i < NumSymbols; i++) begin
          pos_table[i] = '0;
          pos_known[i] = 1'b0;
        end
      end
      default: ;
    endcase
    r.bal = cash_balance;
    r.pos = read_pos(it.sym);
    return r;
  endfunction

  function automatic risk_item_t mk_item(op_e op, logic [7:0] sym, logic side,
                                         logic [2:0] otype, logic [31:0] qty,
                                         logic [31:0] price, logic [31:0] stop,
                                         logic ask_ok, logic [30:0] ask,
                                         logic [31:0] aggr, logic [31:0] rest);
    risk_item_t it;
    it.op = op;
    it.sym = sym;
    it.side = side;
    it.otype = otype;
    it.qty = qty;
    it.price = price;
    it.stop = stop;
    it.ask_ok = ask_ok;
    it.ask = ask;
    it.aggr = aggr;
    it.rest = rest;
    return it;
  endfunction

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 8);
    return $urandom_range(20, 45);
  endfunction

  function automatic logic [31:0] rand_price();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 5000);
    if (r < 85) return $urandom();
    if (r < 95) return -$urandom_range(0, 50);
    return r[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  function automatic risk_item_t random_item();
    risk_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 48) it.op = OP_CHECK;
    else if (r < 93) it.op = OP_TRADE;
    else if (r < 96) it.op = OP_RESET;
    else it.op = OP_NONE;
    it.sym = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 3)) : 8'($urandom());
    it.side = 1'($urandom_range(0, 1));
    it.otype = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 3)) : 3'($urandom());
    r = $urandom_range(0, 99);
    if (r < 70) it.qty = $urandom_range(1, 1000);
    else if (r < 80) it.qty = -$urandom_range(0, 20);
    else if (r < 90) it.qty = $urandom();
    else if (r < 94) it.qty = 32'h7FFF_FFFF;
    else if (r < 97) it.qty = 32'h8000_0000;
    else it.qty = 32'd1;
    it.price = rand_price();
    it.stop = rand_price();
    it.ask_ok = ($urandom_range(0, 99) < 80);
    it.ask = ($urandom_range(0, 99) < 70) ? 31'($urandom_range(0, 10000)) : 31'($urandom());
    it.aggr = $urandom();
    it.rest = $urandom();
    r = $urandom_range(0, 99);
    if (r < 40) it.aggr = own_id;
    else if (r < 75) it.rest = own_id;
    else if (r < 85) begin
      it.aggr = own_id;
      it.rest = own_id;
    end
    return it;
  endfunction

  task automatic send_item(risk_item_t it);
    int gap;
    gap = (no_idle || $urandom_range(0, 99) < 55) ? 0 : idle_length();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= it.op;
    symbol_i       <= it.sym;
    side_i         <= it.side;
    order_type_i   <= it.otype;
    quantity_i     <= it.qty;
    price_i        <= it.price;
    stop_price_i   <= it.stop;
    ask_valid_i    <= it.ask_ok;
    best_ask_i     <= it.ask;
    aggressor_id_i <= it.aggr;
    resting_id_i   <= it.rest;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(risk_keeper_step(it));
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgIdxOwnId) own_id = data[31:0];
    else start_balance = data;
    @(posedge clk_i);
  endtask

  task automatic test_after_reset();
    send_item(mk_item(OP_NONE, 8'd9, 1'b0, OT_LIMIT, 32'd5, 32'd5, 32'd5, 1'b1, 31'd5,
                      32'd1, 32'd2));
    send_item(mk_item(OP_CHECK, 8'd9, 1'b0, OT_LIMIT, 32'd1, 32'd1, 32'd0, 1'b0, 31'd0,
                      32'd0, 32'd0));
    send_item(mk_item(OP_TRADE, 8'd9, 1'b0, OT_LIMIT, 32'd4, 32'd3, 32'd0, 1'b0, 31'd0,
                      32'd0, 32'd7));
    drain_pipeline();
  endtask

  task automatic test_order_checks();
    write_reg(CfgIdxOwnId, 64'h0000_0000_1234_5678);
    write_reg(CfgIdxStartBal, 64'd1_000_000);
    send_item(mk_item(OP_RESET, 8'd5, 1'b0, OT_LIMIT, 32'd0, 32'd0, 32'd0, 1'b0, 31'd0,
                      32'd0, 32'd0));
    send_item(mk_item(OP_CHECK, 8'd5, 1'b0, OT_LIMIT, 32'd0, 32'd100, 32'd0, 1'b0, 31'd0,
                      32'd0, 32'd0));
    send_item(mk_item(OP_CHECK, 8'd5, 1'b0, OT_LIMIT, 32'h8000_0000, 32'd100, 32'd0, 1'b0,
                      31'd0, 32'd0, 32'd0));
    send_item(mk_item(OP_CHECK, 8'd5, 1'b1, OT_LIMIT, 32'd1, 32'd100, 32'd0, 1'b0, 31'd0,
                      32'd0, 32'd0));
    send_item(mk_item(OP_CHECK, 8'd5, 1'b0, OT_LIMIT, 32'd100, 32'd100, 32'd0, 1'b0, 31'd0,
                      32'd0, 32'd0));
    send_item(mk_item(OP_CHECK, 8'd5, 1'b0, OT_STOP_LIMIT, 32'd1000, 32'd1001, 32'd0, 1'b0,
                      31'd0, 32'd0, 32'd0));
    send_item(mk_item(OP_CHECK, 8'd5, 1'b0, OT_STOP_MARKET, 32'd10, -32'sd5, 32'd50, 1'b0,
                      31'd0, 32'd0, 32'd0));
    send_item(mk_item(OP_CHECK, 8'd5, 1'b0, OT_STOP_MARKET, 32'd10, 32'd50, 32'd0, 1'b0,
                      31'd0, 32'd0, 32'd0));
    send_item(mk_item(OP_CHECK, 8'd5, 1'b0, OT_MARKET, 32'd1, 32'd1, 32'd1, 1'b0, 31'd100,
                      32'd0, 32'd0));
    send_item(mk_item(OP_CHECK, 8'd5, 1'b0, OT_MARKET, 32'd1, 32'd1, 32'd1, 1'b1, 31'd0,
                      32'd0, 32'd0));
    send_item(mk_item(OP_CHECK, 8'd5, 1'b0, OT_MARKET, 32'd1, 32'd0, 32'd0, 1'b1, 31'd1,
                      32'd0, 32'd0));
    send_item(mk_item(OP_CHECK, 8'd5, 1'b0, OT_MARKET, 32'd1, 32'd0, 32'd0, 1'b1,
                      31'h7FFF_FFFF, 32'd0, 32'd0));
    send_item(mk_item(OP_CHECK, 8'd5, 1'b0, OT_LIMIT, 32'd1, 32'h8000_0000, 32'd1, 1'b0,
                      31'd0, 32'd0, 32'd0));
    send_item(mk_item(OP_CHECK, 8'd5, 1'b0, 3'd4, 32'd1, 32'd1, 32'd1, 1'b1, 31'd1,
                      32'd0, 32'd0));
    send_item(mk_item(OP_CHECK, 8'd5, 1'b0, 3'd7, 32'd1, 32'd1, 32'd1, 1'b1, 31'd1,
                      32'd0, 32'd0));
  endtask

  task automatic test_trades();
    logic [31:0] me;
    me = own_id;
    send_item(mk_item(OP_TRADE, 8'd5, 1'b0, OT_LIMIT, 32'd10, 32'd100, 32'd0, 1'b0, 31'd0,
                      me, 32'd1));
    send_item(mk_item(OP_TRADE, 8'd5, 1'b0, OT_LIMIT, 32'd3, 32'd7, 32'd0, 1'b0, 31'd0,
                      32'd1, me));
    send_item(mk_item(OP_TRADE, 8'd5, 1'b0, OT_LIMIT, 32'd3, 32'd7, 32'd0, 1'b0, 31'd0,
                      32'd1, 32'd2));
    send_item(mk_item(OP_TRADE, 8'd5, 1'b1, OT_LIMIT, 32'd2, 32'd9, 32'd0, 1'b0, 31'd0,
                      me, me));
    send_item(mk_item(OP_CHECK, 8'd5, 1'b1, OT_LIMIT, 32'd5, 32'd1, 32'd0, 1'b0, 31'd0,
                      32'd0, 32'd0));
    send_item(mk_item(OP_CHECK, 8'd5, 1'b1, OT_LIMIT, 32'd6, 32'd1, 32'd0, 1'b0, 31'd0,
                      32'd0, 32'd0));
    send_item(mk_item(OP_TRADE, 8'd255, 1'b0, OT_LIMIT, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'd0, 1'b0, 31'd0, me, 32'd0));
    send_item(mk_item(OP_TRADE, 8'd0, 1'b0, OT_LIMIT, 32'h8000_0000, 32'h8000_0000,
                      32'd0, 1'b0, 31'd0, 32'd0, me));
    send_item(mk_item(OP_CHECK, 8'd255, 1'b0, OT_LIMIT, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'd0, 1'b0, 31'd0, 32'd0, 32'd0));
    send_item(mk_item(OP_RESET, 8'd255, 1'b0, OT_LIMIT, 32'd0, 32'd0, 32'd0, 1'b0, 31'd0,
                      32'd0, 32'd0));
    drain_pipeline();
  endtask

  task automatic test_register_extremes();
    write_reg(CfgIdxOwnId, {$urandom(), 32'hFFFF_FFFF});
    write_reg(CfgIdxStartBal, 64'h8000_0000_0000_0000);
    send_item(mk_item(OP_RESET, 8'd1, 1'b0, OT_LIMIT, 32'd0, 32'd0, 32'd0, 1'b0, 31'd0,
                      32'd0, 32'd0));
    send_item(mk_item(OP_CHECK, 8'd1, 1'b0, OT_LIMIT, 32'd1, 32'd1, 32'd0, 1'b0, 31'd0,
                      32'd0, 32'd0));
    send_item(mk_item(OP_TRADE, 8'd1, 1'b0, OT_LIMIT, 32'd1, 32'd1, 32'd0, 1'b0, 31'd0,
                      32'd0, 32'hFFFF_FFFF));
    drain_pipeline();
    write_reg(CfgIdxOwnId, 64'hFFFF_FFFF_0000_0000);
    write_reg(CfgIdxStartBal, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(mk_item(OP_RESET, 8'd1, 1'b0, OT_LIMIT, 32'd0, 32'd0, 32'd0, 1'b0, 31'd0,
                      32'd0, 32'd0));
    send_item(mk_item(OP_CHECK, 8'd1, 1'b0, OT_LIMIT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0,
                      1'b0, 31'd0, 32'd0, 32'd0));
    send_item(mk_item(OP_TRADE, 8'd1, 1'b1, OT_LIMIT, 32'd2, 32'd3, 32'd0, 1'b0, 31'd0,
                      32'd0, 32'd5));
    drain_pipeline();
  endtask

  task automatic test_random_traffic();
    int r;
    for (int phase = 0; phase < 6; phase++) begin
      r = $urandom_range(0, 9);
      if (r == 0) write_reg(CfgIdxOwnId, 64'd0);
      else if (r == 1) write_reg(CfgIdxOwnId, 64'hFFFF_FFFF);
      else write_reg(CfgIdxOwnId, {$urandom(), $urandom()});
      r = $urandom_range(0, 9);
      if (r == 0) write_reg(CfgIdxStartBal, 64'h7FFF_FFFF_FFFF_FFFF);
      else if (r == 1) write_reg(CfgIdxStartBal, 64'h8000_0000_0000_0000);
      else if (r == 2) write_reg(CfgIdxStartBal, {$urandom(), $urandom()});
      else write_reg(CfgIdxStartBal, 64'($urandom_range(100_000, 200_000_000)));
      no_idle = (phase == 2);
      send_item(mk_item(OP_RESET, 8'd0, 1'b0, OT_LIMIT, 32'd0, 32'd0, 32'd0, 1'b0, 31'd0,
                        32'd0, 32'd0));
      for (int n = 0; n < PhaseItems; n++) begin
        send_item(random_item());
        if (n % 97 == 96) drain_pipeline();
      end
      drain_pipeline();
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: unexpected result: acc %0b app %0b bal %h pos %h",
                   $realtime, accepted_o, applied_o, balance_now_o, position_now_o);
        mismatch_count++;
      end else begin
        risk_result_t e;
        e = expected_results.pop_front();
        if (accepted_o !== e.acc || applied_o !== e.app ||
            balance_now_o !== e.bal || position_now_o !== e.pos) begin
          if (mismatch_count < 10)
            $display("%0t: expected acc %0b app %0b bal %h pos %h, %s %h pos %h",
                     $realtime, e.acc, e.app, e.bal, e.pos,
                     $sformatf("got acc %0b app %0b bal", accepted_o, applied_o),
                     balance_now_o, position_now_o);
          mismatch_count++;
        end
      end
    end
    if (no_idle) begin
      rx_stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 99) < 65) begin
      out_stall_i <= 1'b0;
    end else begin
      rx_stall_left = idle_length() - 1;
      out_stall_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < NumSymbols; i++) begin
      pos_table[i] = '0;
      pos_known[i] = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_after_reset();
    test_order_checks();
    test_trades();
    test_register_extremes();
    test_random_traffic();
    drain_pipeline();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
